>>> design/rcc_pkg.sv
// shared types, constants and card tables for the colour card classifier
// no dependencies; every other design file refers to this package by scoped names
package rcc_pkg;

  // card table and search tree shape
  localparam int unsigned CardCountDef = 7;
  localparam int unsigned TableSize    = 16;
  localparam int unsigned GroupSize    = 4;
  localparam int unsigned GroupCount   = TableSize / GroupSize;

  // queue between front and back, and front pipeline depth
  localparam int unsigned QueueDepth  = 8;
  localparam int unsigned FrontStages = 3;

  // quotient bits of the pipelined dividers
  localparam int unsigned DivBits = 9;

  // register reset values
  localparam logic [15:0] DarkLimitRst  = 16'd300;
  localparam logic [15:0] WhiteLimitRst = 16'd30000;
  localparam logic [7:0]  GreyLimitRst  = 8'd8;
  localparam logic [15:0] ScaleRedRst   = 16'd4096;
  localparam logic [15:0] ScaleGreenRst = 16'd5435;
  localparam logic [15:0] ScaleBlueRst  = 16'd7770;

  typedef enum logic [2:0] {
    RegDarkLimit  = 3'd0,
    RegWhiteLimit = 3'd1,
    RegGreyLimit  = 3'd2,
    RegScaleRed   = 3'd3,
    RegScaleGreen = 3'd4,
    RegScaleBlue  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] dark_lim;
    logic [15:0] white_lim;
    logic [7:0]  grey_lim;
    logic [15:0] scale_r;
    logic [15:0] scale_g;
    logic [15:0] scale_b;
  } cfg_t;

  // one queued word: class for non-colour readings, else division operands
  typedef struct packed {
    logic        is_col;
    logic [3:0]  cls;
    logic [16:0] hue_num;
    logic [7:0]  hue_den;
    logic [14:0] sat_num;
    logic [7:0]  sat_den;
  } entry_t;

  // card hue table, unused entries zero
  function automatic logic [8:0] card_hue(input logic [3:0] idx);
    logic [8:0] h;
    case (idx)
      4'd0: h = 9'd349;
      4'd1: h = 9'd147;
      4'd2: h = 9'd213;
      4'd3: h = 9'd13;
      4'd4: h = 9'd351;
      4'd5: h = 9'd352;
      4'd6: h = 9'd186;
      default: h = 9'd0;
    endcase
    return h;
  endfunction

  // card saturation table, unused entries zero
  function automatic logic [6:0] card_sat(input logic [3:0] idx);
    logic [6:0] s;
    case (idx)
      4'd0: s = 7'd56;
      4'd1: s = 7'd21;
      4'd2: s = 7'd31;
      4'd3: s = 7'd38;
      4'd4: s = 7'd27;
      4'd5: s = 7'd46;
      4'd6: s = 7'd11;
      default: s = 7'd0;
    endcase
    return s;
  endfunction

endpackage

>>> design/rcc_front.sv
// front end: channel scaling, clear/grey classification, hue and saturation operands
// depends on rcc_pkg
module rcc_front #(
  parameter int unsigned CARD_COUNT = rcc_pkg::CardCountDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rcc_pkg::cfg_t         cfg_i,
  input  logic                  in_valid_i,
  input  logic [15:0]           dark_clear_i,
  input  logic [15:0]           lit_clear_i,
  input  logic [15:0]           red_raw_i,
  input  logic [15:0]           green_raw_i,
  input  logic [15:0]           blue_raw_i,
  output logic                  push_o,
  output rcc_pkg::entry_t       entry_o
);

  function automatic logic [7:0] sat8(input logic [31:0] p);
    return (|p[31:28]) ? 8'hFF : p[27:20];
  endfunction

  // stage 1: gain multiply and saturate
  logic [31:0] prod_r, prod_g, prod_b;
  assign prod_r = 32'(red_raw_i) * 32'(cfg_i.scale_r);
  assign prod_g = 32'(green_raw_i) * 32'(cfg_i.scale_g);
  assign prod_b = 32'(blue_raw_i) * 32'(cfg_i.scale_b);

  logic       v1_q, clr1_q, wht1_q;
  logic [7:0] r1_q, g1_q, b1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    clr1_q <= dark_clear_i > cfg_i.dark_lim;
    wht1_q <= lit_clear_i > cfg_i.white_lim;
    r1_q   <= sat8(prod_r);
    g1_q   <= sat8(prod_g);
    b1_q   <= sat8(prod_b);
  end

  // stage 2: max, min, spread and class for non-colour readings
  logic [7:0] hi_d, lo_d, c_d;
  logic [3:0] cls_d;
  logic       col_d;

  always_comb begin
    hi_d = r1_q;
    lo_d = r1_q;
    if (g1_q > hi_d) hi_d = g1_q;
    if (b1_q > hi_d) hi_d = b1_q;
    if (g1_q < lo_d) lo_d = g1_q;
    if (b1_q < lo_d) lo_d = b1_q;
    c_d   = hi_d - lo_d;
    col_d = !clr1_q && !(c_d < cfg_i.grey_lim);
    if (clr1_q) begin
      cls_d = 4'(CARD_COUNT + 2);
    end else if (wht1_q) begin
      cls_d = 4'(CARD_COUNT);
    end else begin
      cls_d = 4'(CARD_COUNT + 1);
    end
  end

  logic       v2_q, col2_q, hir2_q, hig2_q;
  logic [3:0] cls2_q;
  logic [7:0] hi2_q, lo2_q, c2_q, r2_q, g2_q, b2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    col2_q <= col_d;
    cls2_q <= cls_d;
    hi2_q  <= hi_d;
    lo2_q  <= lo_d;
    c2_q   <= c_d;
    r2_q   <= r1_q;
    g2_q   <= g1_q;
    b2_q   <= b1_q;
    hir2_q <= hi_d == r1_q;
    hig2_q <= hi_d == g1_q;
  end

  // stage 3: hue numerator, saturation numerator and lightness denominator
  logic [18:0] c19, r19, g19, b19, hnum;
  logic [8:0]  sum;
  logic [7:0]  den;
  rcc_pkg::entry_t entry_d;

  always_comb begin
    c19 = 19'(c2_q);
    r19 = 19'(r2_q);
    g19 = 19'(g2_q);
    b19 = 19'(b2_q);
    if (hir2_q) begin
      if (g2_q >= b2_q) begin
        hnum = 19'd60 * (g19 - b19);
      end else begin
        hnum = 19'd360 * c19 - 19'd60 * (b19 - g19);
      end
    end else if (hig2_q) begin
      hnum = 19'd120 * c19 + 19'd60 * b19 - 19'd60 * r19;
    end else begin
      hnum = 19'd240 * c19 + 19'd60 * r19 - 19'd60 * g19;
    end
    sum = 9'(hi2_q) + 9'(lo2_q);
    den = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
    entry_d.is_col  = col2_q;
    entry_d.cls     = cls2_q;
    entry_d.hue_num = hnum[16:0];
    entry_d.hue_den = c2_q;
    entry_d.sat_num = 15'd100 * 15'(c2_q);
    entry_d.sat_den = den;
  end

  logic            v3_q;
  rcc_pkg::entry_t entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign push_o  = v3_q;
  assign entry_o = entry_q;

endmodule

>>> design/rcc_queue.sv
// short word queue between front and back, registered read side
// depends on rcc_pkg
module rcc_queue #(
  parameter int unsigned DEPTH = rcc_pkg::QueueDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  rcc_pkg::entry_t            data_i,
  output logic                       valid_o,
  output rcc_pkg::entry_t            data_o,
  output logic [$clog2(DEPTH+1)-1:0] level_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned LvlW = $clog2(DEPTH + 1);

  rcc_pkg::entry_t mem [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [LvlW-1:0] level_q;
  logic            pop, valid_q;
  rcc_pkg::entry_t data_q;

  // back never stalls, so any stored word leaves at once
  assign pop = level_q != '0;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop) rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      level_q <= level_q + LvlW'(push_i) - LvlW'(pop);
      valid_q <= pop;
    end
  end

  // storage write and registered read
  always_ff @(posedge clk_i) begin
    if (push_i) mem[wr_q] <= data_i;
    if (pop) data_q <= mem[rd_q];
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign level_o = level_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && !pop && level_q == LvlW'(DEPTH)))
    else $error("queue overflow");

endmodule

>>> design/rcc_back.sv
// back end: pipelined hue and saturation dividers, nearest card search, result strobe
// depends on rcc_pkg
module rcc_back #(
  parameter int unsigned CARD_COUNT = rcc_pkg::CardCountDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  rcc_pkg::entry_t entry_i,
  output logic            done_o,
  output logic [3:0]      card_class_o,
  output logic [8:0]      hue_deg_o,
  output logic [6:0]      sat_pct_o
);

  localparam int unsigned NB = rcc_pkg::DivBits;
  localparam int unsigned NT = rcc_pkg::TableSize;
  localparam int unsigned GS = rcc_pkg::GroupSize;
  localparam int unsigned NG = rcc_pkg::GroupCount;

  typedef struct packed {
    logic        valid;
    logic        is_col;
    logic [3:0]  cls;
    logic [16:0] hrem;
    logic [7:0]  hden;
    logic [8:0]  hq;
    logic [14:0] srem;
    logic [7:0]  sden;
    logic [8:0]  sq;
  } div_t;

  div_t div_q [NB+1];
  div_t div_d [NB];

  // one quotient bit per stage for both divisions
  always_comb begin
    logic [16:0] hsh, ssh, srem17;
    for (int s = 0; s < NB; s++) begin
      div_d[s] = div_q[s];
      hsh = 17'(div_q[s].hden) << (NB - 1 - s);
      ssh = 17'(div_q[s].sden) << (NB - 1 - s);
      srem17 = 17'(div_q[s].srem);
      if (div_q[s].hrem >= hsh) begin
        div_d[s].hrem = div_q[s].hrem - hsh;
        div_d[s].hq[NB-1-s] = 1'b1;
      end
      if (srem17 >= ssh) begin
        div_d[s].srem = 15'(srem17 - ssh);
        div_d[s].sq[NB-1-s] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= NB; s++) div_q[s] <= '0;
    end else begin
      div_q[0].valid   <= valid_i;
      div_q[0].is_col  <= entry_i.is_col;
      div_q[0].cls     <= entry_i.cls;
      div_q[0].hrem    <= entry_i.hue_num;
      div_q[0].hden    <= entry_i.hue_den;
      div_q[0].hq      <= '0;
      div_q[0].srem    <= entry_i.sat_num;
      div_q[0].sden    <= entry_i.sat_den;
      div_q[0].sq      <= '0;
      for (int s = 0; s < NB; s++) div_q[s+1] <= div_d[s];
    end
  end

  // final hue and saturation, zero divisor gives zero
  logic       mid_v_q, mid_col_q;
  logic [3:0] mid_cls_q;
  logic [8:0] mid_hue_q;
  logic [6:0] mid_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_v_q <= 1'b0;
    end else begin
      mid_v_q <= div_q[NB].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    mid_col_q <= div_q[NB].is_col;
    mid_cls_q <= div_q[NB].cls;
    mid_hue_q <= (div_q[NB].hden == '0) ? '0 : div_q[NB].hq;
    mid_sat_q <= (div_q[NB].sden == '0) ? '0 : div_q[NB].sq[6:0];
  end

  // distance to every card, unused cards get the largest distance
  logic [16:0] dist_d [NT];

  always_comb begin
    logic [8:0] ch, diff;
    logic [7:0] t, hd;
    logic [6:0] cs, sd;
    for (int i = 0; i < NT; i++) begin
      ch   = rcc_pkg::card_hue(4'(i));
      cs   = rcc_pkg::card_sat(4'(i));
      diff = (mid_hue_q >= ch) ? mid_hue_q - ch : ch - mid_hue_q;
      t    = (diff >= 9'd180) ? 8'(diff - 9'd180) : 8'(9'd180 - diff);
      hd   = 8'd180 - t;
      sd   = (mid_sat_q >= cs) ? mid_sat_q - cs : cs - mid_sat_q;
      if (i < CARD_COUNT) begin
        dist_d[i] = 17'(hd) * 17'(hd) + 17'(sd) * 17'(sd);
      end else begin
        dist_d[i] = '1;
      end
    end
  end

  logic        dst_v_q, dst_col_q;
  logic [3:0]  dst_cls_q;
  logic [8:0]  dst_hue_q;
  logic [6:0]  dst_sat_q;
  logic [16:0] dist_q [NT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_v_q <= 1'b0;
    end else begin
      dst_v_q <= mid_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dst_col_q <= mid_col_q;
    dst_cls_q <= mid_cls_q;
    dst_hue_q <= mid_hue_q;
    dst_sat_q <= mid_sat_q;
    for (int i = 0; i < NT; i++) dist_q[i] <= dist_d[i];
  end

  // first level of the search tree, earlier card wins a tie
  logic [16:0] gmin_d [NG];
  logic [3:0]  gidx_d [NG];

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      gmin_d[g] = dist_q[g*GS];
      gidx_d[g] = 4'(g * GS);
      for (int j = 1; j < GS; j++) begin
        if (dist_q[g*GS+j] < gmin_d[g]) begin
          gmin_d[g] = dist_q[g*GS+j];
          gidx_d[g] = 4'(g * GS + j);
        end
      end
    end
  end

  logic        grp_v_q, grp_col_q;
  logic [3:0]  grp_cls_q;
  logic [8:0]  grp_hue_q;
  logic [6:0]  grp_sat_q;
  logic [16:0] gmin_q [NG];
  logic [3:0]  gidx_q [NG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_v_q <= 1'b0;
    end else begin
      grp_v_q <= dst_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_col_q <= dst_col_q;
    grp_cls_q <= dst_cls_q;
    grp_hue_q <= dst_hue_q;
    grp_sat_q <= dst_sat_q;
    for (int g = 0; g < NG; g++) begin
      gmin_q[g] <= gmin_d[g];
      gidx_q[g] <= gidx_d[g];
    end
  end

  // second level of the search tree
  logic [16:0] best;
  logic [3:0]  best_idx;

  always_comb begin
    best     = gmin_q[0];
    best_idx = gidx_q[0];
    for (int g = 1; g < NG; g++) begin
      if (gmin_q[g] < best) begin
        best     = gmin_q[g];
        best_idx = gidx_q[g];
      end
    end
  end

  // result registers, one strobe per word
  logic       done_q;
  logic [3:0] cls_q;
  logic [8:0] hue_q;
  logic [6:0] sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= grp_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q <= grp_col_q ? best_idx : grp_cls_q;
    hue_q <= grp_col_q ? grp_hue_q : '0;
    sat_q <= grp_col_q ? grp_sat_q : '0;
  end

  assign done_o       = done_q;
  assign card_class_o = cls_q;
  assign hue_deg_o    = hue_q;
  assign sat_pct_o    = sat_q;

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_q[NB].valid && div_q[NB].hden != '0 |-> div_q[NB].hq < 9'd360)
    else $error("hue quotient out of range");

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_q[NB].valid && div_q[NB].sden != '0 |-> div_q[NB].sq <= 9'd100)
    else $error("saturation quotient out of range");

  a_strobe_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(dst_v_q, 2))
    else $error("result strobe without a word in the search");

endmodule

>>> design/rgb_colour_card_classifier.sv
// top level: configuration registers, front end, word queue and back end
// depends on rcc_pkg, rcc_front, rcc_queue, rcc_back
//
// One reading is taken per clock while busy is low, and results leave on
// done_o in order, one per cycle at full rate. A reading passes through the
// three front stages, the queue write and registered read, the nine one-bit
// divider stages shared by hue and saturation, the final hue and saturation
// register and the three stages of the nearest card search. The receiver
// cannot stall: each result is on the ports for one cycle only. busy rises
// while the queue holds QueueDepth - FrontStages words or more.
// Write configuration only while no reading is in flight.
module rgb_colour_card_classifier #(
  parameter int unsigned CARD_COUNT = rcc_pkg::CardCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] dark_clear_i,
  input  logic [15:0] lit_clear_i,
  input  logic [15:0] red_raw_i,
  input  logic [15:0] green_raw_i,
  input  logic [15:0] blue_raw_i,
  output logic        done_o,
  output logic [3:0]  card_class_o,
  output logic [8:0]  hue_deg_o,
  output logic [6:0]  sat_pct_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned LvlW = $clog2(rcc_pkg::QueueDepth + 1);

  // configuration registers
  rcc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dark_lim  <= rcc_pkg::DarkLimitRst;
      cfg_q.white_lim <= rcc_pkg::WhiteLimitRst;
      cfg_q.grey_lim  <= rcc_pkg::GreyLimitRst;
      cfg_q.scale_r   <= rcc_pkg::ScaleRedRst;
      cfg_q.scale_g   <= rcc_pkg::ScaleGreenRst;
      cfg_q.scale_b   <= rcc_pkg::ScaleBlueRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (rcc_pkg::reg_idx_e'(cfg_index_i))
        rcc_pkg::RegDarkLimit:  cfg_q.dark_lim  <= cfg_data_i;
        rcc_pkg::RegWhiteLimit: cfg_q.white_lim <= cfg_data_i;
        rcc_pkg::RegGreyLimit:  cfg_q.grey_lim  <= cfg_data_i[7:0];
        rcc_pkg::RegScaleRed:   cfg_q.scale_r   <= cfg_data_i;
        rcc_pkg::RegScaleGreen: cfg_q.scale_g   <= cfg_data_i;
        rcc_pkg::RegScaleBlue:  cfg_q.scale_b   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // accept and credit check against the queue
  logic            in_valid, push, q_valid;
  rcc_pkg::entry_t push_word, q_word;
  logic [LvlW-1:0] level;

  assign busy     = level >= LvlW'(rcc_pkg::QueueDepth - rcc_pkg::FrontStages);
  assign in_valid = start && !busy;

  rcc_front #(.CARD_COUNT(CARD_COUNT)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid),
    .dark_clear_i(dark_clear_i),
    .lit_clear_i (lit_clear_i),
    .red_raw_i   (red_raw_i),
    .green_raw_i (green_raw_i),
    .blue_raw_i  (blue_raw_i),
    .push_o      (push),
    .entry_o     (push_word)
  );

  rcc_queue #(.DEPTH(rcc_pkg::QueueDepth)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_word),
    .valid_o(q_valid),
    .data_o (q_word),
    .level_o(level)
  );

  rcc_back #(.CARD_COUNT(CARD_COUNT)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .entry_i     (q_word),
    .done_o      (done_o),
    .card_class_o(card_class_o),
    .hue_deg_o   (hue_deg_o),
    .sat_pct_o   (sat_pct_o)
  );

endmodule

>>> bench/rgb_colour_card_classifier_check.sv
// checker for the colour card classifier: tracks register writes, predicts each word
// and compares results in order; depends on rcc_pkg for the register index codes, reset values and config type
`timescale 1ns / 1ps

module rgb_colour_card_classifier_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] dark_clear_i,
  input  logic [15:0] lit_clear_i,
  input  logic [15:0] red_raw_i,
  input  logic [15:0] green_raw_i,
  input  logic [15:0] blue_raw_i,
  input  logic        done_o,
  input  logic [3:0]  card_class_o,
  input  logic [8:0]  hue_deg_o,
  input  logic [6:0]  sat_pct_o,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          pending_o,
  output int          fail_count_o
);

  localparam int CardCount = 7;
  localparam logic [3:0] ClassWhite = 4'(CardCount);
  localparam logic [3:0] ClassBlack = 4'(CardCount + 1);
  localparam logic [3:0] ClassClear = 4'(CardCount + 2);

  typedef struct packed {
    logic [3:0] card;
    logic [8:0] hue;
    logic [6:0] sat;
  } verdict_t;

  // local copy of the card table
  int card_hue_tab[CardCount] = '{349, 147, 213, 13, 351, 352, 186};
  int card_sat_tab[CardCount] = '{56, 21, 31, 38, 27, 46, 11};

  rcc_pkg::cfg_t cfg_q;
  verdict_t      verdict_fifo[$];

  assign pending_o = verdict_fifo.size();

  function automatic int gain_scale(logic [15:0] raw, logic [15:0] gain);
    logic [31:0] prod;
    prod = raw * gain;
    return (prod >> 20) > 255 ? 255 : int'(prod >> 20);
  endfunction

  function automatic int iabs(int a);
    return a < 0 ? -a : a;
  endfunction

  // predicted class, hue and saturation of one reading
  function automatic verdict_t classify(rcc_pkg::cfg_t cfg, logic [15:0] dark,
                                        logic [15:0] lit, logic [15:0] rr,
                                        logic [15:0] gr, logic [15:0] br);
    verdict_t v;
    int r, g, b, hi, lo, c, hue, sat, sum, den, best, hd, sd, sq_dist;
    v = '0;
    if (dark > cfg.dark_lim) begin
      v.card = ClassClear;
      return v;
    end
    r = gain_scale(rr, cfg.scale_r);
    g = gain_scale(gr, cfg.scale_g);
    b = gain_scale(br, cfg.scale_b);
    hi = r; lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    c = hi - lo;
    if (c < int'(cfg.grey_lim)) begin
      v.card = (lit > cfg.white_lim) ? ClassWhite : ClassBlack;
      return v;
    end
    if (c == 0) hue = 0;
    else if (hi == r) hue = (g >= b) ? (60 * (g - b)) / c : (360 * c - 60 * (b - g)) / c;
    else if (hi == g) hue = (120 * c + 60 * b - 60 * r) / c;
    else hue = (240 * c + 60 * r - 60 * g) / c;
    sum = hi + lo;
    den = (sum <= 255) ? sum : 510 - sum;
    sat = (den == 0) ? 0 : (100 * c) / den;
    // nearest card, first one wins ties
    best = 32'h7fff_ffff;
    for (int i = 0; i < CardCount; i++) begin
      hd = 180 - iabs(iabs(card_hue_tab[i] - hue) - 180);
      sd = card_sat_tab[i] - sat;
      sq_dist = hd * hd + sd * sd;
      if (sq_dist < best) begin
        best = sq_dist;
        v.card = 4'(i);
      end
    end
    v.hue = 9'(hue);
    v.sat = 7'(sat);
    return v;
  endfunction

  // register shadow, prediction and comparison
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      cfg_q <= '{dark_lim: rcc_pkg::DarkLimitRst, white_lim: rcc_pkg::WhiteLimitRst,
                 grey_lim: rcc_pkg::GreyLimitRst, scale_r: rcc_pkg::ScaleRedRst,
                 scale_g: rcc_pkg::ScaleGreenRst, scale_b: rcc_pkg::ScaleBlueRst};
      verdict_fifo.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          rcc_pkg::RegDarkLimit:  cfg_q.dark_lim  <= cfg_data_i;
          rcc_pkg::RegWhiteLimit: cfg_q.white_lim <= cfg_data_i;
          rcc_pkg::RegGreyLimit:  cfg_q.grey_lim  <= cfg_data_i[7:0];
          rcc_pkg::RegScaleRed:   cfg_q.scale_r   <= cfg_data_i;
          rcc_pkg::RegScaleGreen: cfg_q.scale_g   <= cfg_data_i;
          rcc_pkg::RegScaleBlue:  cfg_q.scale_b   <= cfg_data_i;
          default: ;
        endcase
      end
      if (start && !busy)
        verdict_fifo.push_back(classify(cfg_q, dark_clear_i, lit_clear_i,
                                        red_raw_i, green_raw_i, blue_raw_i));
      if (done_o) begin
        if (verdict_fifo.size() == 0) begin
          if (fail_count_o < 10)
            $display("result word with nothing expected: class %0d hue %0d sat %0d",
                      card_class_o, hue_deg_o, sat_pct_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = verdict_fifo.pop_front();
          if (want != {card_class_o, hue_deg_o, sat_pct_o}) begin
            if (fail_count_o < 10)
              $display("mismatch: class %0d/%0d hue %0d/%0d sat %0d/%0d (expected/actual)",
                       want.card, card_class_o, want.hue, hue_deg_o, want.sat, sat_pct_o);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

>>> bench/rgb_colour_card_classifier_test.sv
// top of the colour card classifier bench: clock, reset, register phases and readings
// depends on rcc_pkg, rgb_colour_card_classifier and rgb_colour_card_classifier_check
`timescale 1ns / 1ps

module rgb_colour_card_classifier_test;

  localparam logic [2:0] SpareIdxLo = 3'd6;
  localparam logic [2:0] SpareIdxHi = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] dark_clear_i = '0, lit_clear_i = '0;
  logic [15:0] red_raw_i = '0, green_raw_i = '0, blue_raw_i = '0;
  logic        done_o;
  logic [3:0]  card_class_o;
  logic [8:0]  hue_deg_o;
  logic [6:0]  sat_pct_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  int          pending, fail_count;

  // bench-side view of the settings, used only to aim the stimulus
  logic [15:0] dark_lim = rcc_pkg::DarkLimitRst;
  logic [15:0] gain_r = rcc_pkg::ScaleRedRst;
  logic [15:0] gain_g = rcc_pkg::ScaleGreenRst;
  logic [15:0] gain_b = rcc_pkg::ScaleBlueRst;
  bit          no_idle;

  always #5 clk_i = ~clk_i;

  rgb_colour_card_classifier u_dut (.*);

  rgb_colour_card_classifier_check u_check (
    .*, .pending_o(pending), .fail_count_o(fail_count)
  );

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // stop sending, wait for the pipeline to drain, then load a full register set
  task automatic load_settings(logic [15:0] dl, logic [15:0] wl, logic [7:0] gl,
                               logic [15:0] sr, logic [15:0] sg, logic [15:0] sb);
    @(negedge clk_i);
    start = 1'b0;
    wait (pending == 0);
    repeat (25) @(negedge clk_i);
    write_reg(rcc_pkg::RegDarkLimit, dl);
    write_reg(rcc_pkg::RegWhiteLimit, wl);
    write_reg(rcc_pkg::RegGreyLimit, {8'(16'($urandom)), gl});
    write_reg(rcc_pkg::RegScaleRed, sr);
    write_reg(rcc_pkg::RegScaleGreen, sg);
    write_reg(rcc_pkg::RegScaleBlue, sb);
    write_reg(($urandom_range(0, 1) != 0) ? SpareIdxLo : SpareIdxHi, 16'($urandom));
    dark_lim = dl; gain_r = sr; gain_g = sg; gain_b = sb;
  endtask

  // one reading word, then the sender's own pause
  task automatic send_reading(logic [15:0] dk, logic [15:0] lt, logic [15:0] rr,
                              logic [15:0] gr, logic [15:0] br);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    @(negedge clk_i);
    start = 1'b1;
    dark_clear_i = dk; lit_clear_i = lt;
    red_raw_i = rr; green_raw_i = gr; blue_raw_i = br;
    do @(posedge clk_i); while (busy);
    if (gap > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // raw count that lands near a chosen scaled level
  function automatic logic [15:0] raw_for(int level, logic [15:0] gain);
    longint v;
    if (gain == 0) return 16'($urandom);
    v = ((longint'(level) << 20) + gain - 1) / gain + $urandom_range(0, 2);
    return v > 65535 ? 16'hffff : 16'(v);
  endfunction

  task automatic random_readings(int count);
    int kind, lvl, w;
    logic [15:0] dk;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      dk = 16'($urandom_range(0, dark_lim));
      if (kind < 8) begin
        send_reading(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
      end else if (kind < 30) begin
        // near-grey readings around the spread threshold
        lvl = $urandom_range(0, 255);
        send_reading(dk, 16'($urandom), raw_for(lvl, gain_r),
                     raw_for(lvl + $urandom_range(0, 10), gain_g),
                     raw_for(lvl + $urandom_range(0, 10), gain_b));
      end else begin
        w = $urandom_range(6, 16);
        send_reading(dk, 16'($urandom), 16'($urandom) >> (16 - w),
                     16'($urandom) >> (16 - w), 16'($urandom) >> (16 - w));
      end
    end
  endtask

  // stimulus
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed readings at reset settings
    send_reading(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_reading(16'd301, 16'd0, 16'hffff, 16'd0, 16'd0);
    send_reading(16'd300, 16'd0, 16'hffff, 16'd0, 16'd0);
    send_reading(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_reading(16'd0, 16'hffff, 16'd0, 16'd0, 16'd0);
    send_reading(16'd0, 16'd30000, 16'd0, 16'd0, 16'd0);
    send_reading(16'd0, 16'd30001, 16'hffff, 16'hffff, 16'hffff);
    send_reading(16'd0, 16'd0, 16'hffff, 16'd0, 16'd0);
    send_reading(16'd0, 16'd0, 16'd0, 16'hffff, 16'd0);
    send_reading(16'd0, 16'd0, 16'd0, 16'd0, 16'hffff);
    send_reading(16'd0, 16'd0, 16'hffff, 16'd0, 16'h4000);
    send_reading(16'd0, 16'd0, 16'hffff, 16'hc000, 16'd0);
    send_reading(16'd0, 16'd0, 16'h0800, 16'h0600, 16'h2000);
    send_reading(16'd0, 16'd0, 16'h0800, 16'h0000, 16'h0000);
    send_reading(16'd0, 16'd0, 16'h0700, 16'h0000, 16'h0000);
    send_reading(16'd0, 16'd0, 16'h8000, 16'h0100, 16'h0300);
    send_reading(16'd0, 16'd0, 16'h2000, 16'h3000, 16'h1800);
    send_reading(16'd0, 16'd0, 16'h5555, 16'haaaa, 16'h5555);
    random_readings(230);

    load_settings(16'($urandom_range(200, 3000)), 16'($urandom), 8'($urandom_range(0, 30)),
                  16'($urandom_range(2048, 16384)), 16'($urandom_range(2048, 16384)),
                  16'($urandom_range(2048, 16384)));
    random_readings(250);
    // zero gains, no grey band: no chroma and lightness at the low end
    load_settings(16'hffff, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0);
    random_readings(80);
    // full scale: channels saturate and the grey band is at its widest
    load_settings(16'hffff, 16'hffff, 8'd255, 16'hffff, 16'hffff, 16'hffff);
    random_readings(100);
    // dark limit zero with full gains and the narrowest grey band
    load_settings(16'd0, 16'd100, 8'd1, 16'hffff, 16'hffff, 16'hffff);
    random_readings(120);
    load_settings(16'($urandom), 16'($urandom), 8'($urandom_range(0, 255)), 16'($urandom),
                  16'($urandom), 16'($urandom));
    random_readings(200);
    load_settings(rcc_pkg::DarkLimitRst, rcc_pkg::WhiteLimitRst, rcc_pkg::GreyLimitRst,
                  rcc_pkg::ScaleRedRst, rcc_pkg::ScaleGreenRst, rcc_pkg::ScaleBlueRst);
    random_readings(300);

    @(negedge clk_i);
    start = 1'b0;
    wait (pending == 0);
    repeat (30) @(posedge clk_i);
    if (fail_count == 0)
      $display("[rgb_colour_card_classifier] OK");
    else
      $display("[rgb_colour_card_classifier] ERROR");
    $finish;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("[rgb_colour_card_classifier] ERROR");
    $finish;
  end

endmodule
